// File: rtl/six_axis_force_torque_conversion_macros.svh
// Assertion macros shared by the force/torque conversion RTL
`ifndef SIX_AXIS_FORCE_TORQUE_CONVERSION_MACROS_SVH
`define SIX_AXIS_FORCE_TORQUE_CONVERSION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFTC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SFTC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sftc_pkg.sv
// Shared types, constants and calibration coefficients for the force/torque conversion
package sftc_pkg;

    localparam int N_CH       = 6;
    localparam int N_COEF     = N_CH * N_CH;
    localparam int CH_IDX_W   = 3;
    localparam int COEF_IDX_W = 6;
    localparam int VOLT_W     = 16;
    localparam int D_W        = 17;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = COEF_W + D_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int OUT_W      = 32;
    localparam int RND_SH     = 11;
    localparam int RND_HALF   = 1 << (RND_SH - 1);
    localparam int SPA_W      = 11;
    localparam int IN_DATA_W  = N_CH * VOLT_W;
    localparam int OUT_DATA_W = N_CH * OUT_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    typedef enum logic
    {
        OP_MEASURE = 1'b0,
        OP_OFFSET  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic                valid;
        logic [CH_IDX_W-1:0] idx;
        logic [D_W-1:0]      value;
    } mac_load_t;

    typedef struct packed
    {
        logic                valid;
        logic [CH_IDX_W-1:0] row;
        logic [OUT_W-1:0]    value;
    } mac_res_t;

    // Calibration matrix, row-major, Q15.16
    function automatic logic signed [COEF_W-1:0] coef_rom(input logic [COEF_IDX_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            6'd0:    c = 32'sd143;
            6'd1:    c = 32'sd509;
            6'd2:    c = -32'sd5067;
            6'd3:    c = -32'sd217024;
            6'd4:    c = 32'sd1482;
            6'd5:    c = 32'sd215589;
            6'd6:    c = -32'sd1740;
            6'd7:    c = 32'sd265964;
            6'd8:    c = -32'sd4017;
            6'd9:    c = -32'sd123758;
            6'd10:   c = -32'sd489;
            6'd11:   c = -32'sd125769;
            6'd12:   c = 32'sd248437;
            6'd13:   c = 32'sd131;
            6'd14:   c = 32'sd249991;
            6'd15:   c = -32'sd4060;
            6'd16:   c = 32'sd250041;
            6'd17:   c = -32'sd4861;
            6'd18:   c = -32'sd50630;
            6'd19:   c = 32'sd1601312;
            6'd20:   c = 32'sd1369506;
            6'd21:   c = -32'sd766155;
            6'd22:   c = -32'sd1424086;
            6'd23:   c = -32'sd733852;
            6'd24:   c = -32'sd1545934;
            6'd25:   c = -32'sd5793;
            6'd26:   c = 32'sd837068;
            6'd27:   c = 32'sd1299424;
            6'd28:   c = 32'sd851258;
            6'd29:   c = -32'sd1317759;
            6'd30:   c = 32'sd912;
            6'd31:   c = 32'sd942802;
            6'd32:   c = 32'sd24145;
            6'd33:   c = 32'sd916621;
            6'd34:   c = 32'sd16861;
            6'd35:   c = 32'sd953783;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/six_axis_force_torque_conversion.sv
// Six-axis force/torque conversion: run averaging, zero offset, calibration matrix
//
//  channel   dir  payload                                         accepted when
//  s_axis    in   tuser: opcode; tdata: volt_ch0..volt_ch5        tvalid & tready
//  m_axis    out  tdata: force_x,y,z, torque_x,y,z                tvalid & tready
//  apb       in   samples_per_average at byte address 0           psel & penable & pwrite
//
//  A sample that does not end a run does six read-modify-writes of the sum memory.
//  The sample that ends a run then divides the six sums in turn on the shared bit-serial
//  divider; a measure run then passes the 36 products through the single 32x17 multiplier.
//  Reset needs no clearing pass: a zero sample count and an offset-valid flag stand in.
//  A result waits in the output register; input keeps flowing until the next matrix
//  product, which holds, and with it the input, until that result is taken.
`include "six_axis_force_torque_conversion_macros.svh"

module six_axis_force_torque_conversion #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sftc_pkg::APB_AW-1:0]       paddr,
    input  logic [sftc_pkg::APB_DW-1:0]       pwdata,
    output logic [sftc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // volt_ch0 [15:0], volt_ch1, volt_ch2, volt_ch3, volt_ch4, volt_ch5 [95:80]
    input  logic [sftc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode [0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // force_x [31:0], force_y, force_z, torque_x, torque_y, torque_z [191:160]
    output logic [sftc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import sftc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = VOLT_W + CNT_W;
    localparam int CMP_W = (CNT_W > SPA_W) ? CNT_W : SPA_W;
    localparam logic REG_SPA = 1'b0;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ACC,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MAC_GO,
        ST_MAC
    } state_t;

    state_t               state_reg;
    logic [SPA_W-1:0]     spa_reg;
    opcode_t              op_reg;
    opcode_t              mode_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     dsor_reg;
    logic                 fresh_reg;
    logic                 run_end_reg;
    logic [CH_IDX_W-1:0]  ch_reg;
    logic                 wr_pend_reg;
    logic [CH_IDX_W-1:0]  wr_ch_reg;
    logic                 offs_vld_reg;
    logic                 m_tvalid_reg;
    logic [VOLT_W-1:0]    samp_reg [N_CH];
    logic [OUT_W-1:0]     out_reg [N_CH];

    logic [SUM_W-1:0]     sum_mem [N_CH];
    logic [SUM_W-1:0]     sum_rd_reg;
    logic [VOLT_W-1:0]    offs_mem [N_CH];
    logic [VOLT_W-1:0]    offs_rd_reg;

    logic                 cfg_wr;
    logic                 in_acc;
    opcode_t              in_op;
    logic                 fresh;
    logic [CNT_W-1:0]     cnt_new;
    logic                 run_done;
    logic                 sum_re;
    logic                 sum_we;
    logic [SUM_W-1:0]     sum_base;
    logic [SUM_W-1:0]     sum_wd;
    logic                 offs_re;
    logic                 offs_we;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     div_q;
    logic [VOLT_W-1:0]    q16;
    logic [VOLT_W-1:0]    off16;
    logic [D_W-1:0]       diff;
    mac_load_t            mac_load;
    logic                 mac_start;
    mac_res_t             mac_res;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPA) ? APB_DW'(spa_reg) : '0;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op         = opcode_t'(s_axis_tuser[0]);

    // A new run starts on an empty count or on a change of opcode
    assign fresh    = (cnt_reg == '0) || (in_op != mode_reg);
    assign cnt_new  = fresh ? CNT_W'(1) : cnt_reg + 1'b1;
    assign run_done = (CMP_W'(cnt_new) >= CMP_W'(spa_reg))
                   || (CMP_W'(cnt_new) >= CMP_W'(MAX_SAMPLES));

    assign sum_re   = ((state_reg == ST_ACC) && (ch_reg < CH_IDX_W'(N_CH)))
                   || (state_reg == ST_DIV_RD);
    assign sum_we   = wr_pend_reg;
    assign sum_base = fresh_reg ? '0 : sum_rd_reg;
    assign sum_wd   = sum_base + SUM_W'(signed'(samp_reg[wr_ch_reg]));

    assign offs_re   = (state_reg == ST_DIV_RD);
    assign div_start = (state_reg == ST_DIV_GO);
    assign q16       = div_q[VOLT_W-1:0];
    assign off16     = offs_vld_reg ? offs_rd_reg : '0;
    // Difference of two 16-bit values always fits 17 bits, so the clamp never engages
    assign diff      = D_W'(signed'(q16)) - D_W'(signed'(off16));
    assign offs_we   = (state_reg == ST_DIV_WAIT) && div_done && (op_reg == OP_OFFSET);

    assign mac_load.valid = (state_reg == ST_DIV_WAIT) && div_done && (op_reg == OP_MEASURE);
    assign mac_load.idx   = ch_reg;
    assign mac_load.value = diff;
    assign mac_start      = (state_reg == ST_MAC_GO) && !m_tvalid_reg;

    sftc_div #(
        .DEND_W (SUM_W),
        .DSOR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_rd_reg),
        .divisor  (dsor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    sftc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (mac_load),
        .start (mac_start),
        .res   (mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            spa_reg      <= SPA_W'(1);
            op_reg       <= OP_MEASURE;
            mode_reg     <= OP_MEASURE;
            cnt_reg      <= '0;
            dsor_reg     <= '0;
            fresh_reg    <= 1'b0;
            run_end_reg  <= 1'b0;
            ch_reg       <= '0;
            wr_pend_reg  <= 1'b0;
            wr_ch_reg    <= '0;
            offs_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_SPA))
            begin
                spa_reg <= pwdata[SPA_W-1:0];
            end
            if (m_tvalid_reg && m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            // Sum written back in the cycle after its read
            wr_pend_reg <= (state_reg == ST_ACC) && (ch_reg < CH_IDX_W'(N_CH));
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg      <= in_op;
                        mode_reg    <= in_op;
                        fresh_reg   <= fresh;
                        cnt_reg     <= run_done ? '0 : cnt_new;
                        dsor_reg    <= cnt_new;
                        run_end_reg <= run_done;
                        ch_reg      <= '0;
                        state_reg   <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    // Read issued here, sum written back in the next cycle
                    if (ch_reg < CH_IDX_W'(N_CH))
                    begin
                        wr_ch_reg   <= ch_reg;
                        ch_reg      <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        ch_reg    <= '0;
                        state_reg <= run_end_reg ? ST_DIV_RD : ST_IDLE;
                    end
                end
                ST_DIV_RD:
                begin
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (ch_reg == CH_IDX_W'(N_CH - 1))
                        begin
                            ch_reg <= '0;
                            if (op_reg == OP_OFFSET)
                            begin
                                offs_vld_reg <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_MAC_GO;
                            end
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_DIV_RD;
                        end
                    end
                end
                ST_MAC_GO:
                begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg)
                    begin
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    if (mac_res.valid && (mac_res.row == CH_IDX_W'(N_CH - 1)))
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int c = 0; c < N_CH; c++)
            begin
                samp_reg[c] <= s_axis_tdata[c*VOLT_W +: VOLT_W];
            end
        end
        if (mac_res.valid)
        begin
            out_reg[mac_res.row] <= mac_res.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[wr_ch_reg] <= sum_wd;
        end
        if (sum_re)
        begin
            sum_rd_reg <= sum_mem[ch_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (offs_we)
        begin
            offs_mem[ch_reg] <= q16;
        end
        if (offs_re)
        begin
            offs_rd_reg <= offs_mem[ch_reg];
        end
    end

    always_comb
    begin
        for (int c = 0; c < N_CH; c++)
        begin
            m_axis_tdata[c*OUT_W +: OUT_W] = out_reg[c];
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;

    `SFTC_ASSERT_NEXT(a_accept_drops_ready, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready held after a request")
    `SFTC_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, mac_res.valid, !m_axis_tvalid, "matrix row written over a held result")
    `SFTC_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_done, state_reg == ST_DIV_WAIT, "divider finished outside its wait state")

endmodule

// File: rtl/sftc_div.sv
// Radix-2 restoring divider: signed dividend by unsigned divisor, truncating toward zero
module sftc_div #(
    parameter int DEND_W = 27,
    parameter int DSOR_W = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEND_W-1:0] dividend,
    input  logic [DSOR_W-1:0] divisor,
    output logic              done,
    output logic [DEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DEND_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [DEND_W-1:0] mag_reg;
    logic [DEND_W-1:0] mag_next;
    logic [DSOR_W-1:0] rem_reg;
    logic [DSOR_W-1:0] rem_next;
    logic [DSOR_W-1:0] dsor_reg;
    logic [DSOR_W:0]   rem_sh;
    logic [DSOR_W:0]   rem_diff;
    logic              ge;

    always_comb
    begin
        rem_sh   = {rem_reg, mag_reg[DEND_W-1]};
        rem_diff = rem_sh - {1'b0, dsor_reg};
        ge       = (rem_sh >= {1'b0, dsor_reg});
        rem_next = ge ? rem_diff[DSOR_W-1:0] : rem_sh[DSOR_W-1:0];
        mag_next = {mag_reg[DEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(DEND_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Work on the magnitude, restore the sign at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[DEND_W-1];
            mag_reg  <= dividend[DEND_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~mag_reg + 1'b1) : mag_reg;

endmodule

// File: rtl/sftc_mac.sv
// Calibration matrix product: one 32x17 multiply per cycle, row accumulate, round and saturate
module sftc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  sftc_pkg::mac_load_t load,
    input  logic                start,
    output sftc_pkg::mac_res_t  res
);
    import sftc_pkg::*;

    localparam int SHF_W = ACC_W - RND_SH;
    localparam int TOP_W = SHF_W - OUT_W + 1;

    logic signed [D_W-1:0]    d_reg [N_CH];
    logic                     run_reg;
    logic                     run_next;
    logic [COEF_IDX_W-1:0]    k_reg;
    logic [COEF_IDX_W-1:0]    k_next;
    logic [CH_IDX_W-1:0]      i_reg;
    logic [CH_IDX_W-1:0]      i_next;
    logic [CH_IDX_W-1:0]      r_reg;
    logic [CH_IDX_W-1:0]      r_next;
    logic                     p_vld_reg;
    logic                     p_first_reg;
    logic                     p_last_reg;
    logic [CH_IDX_W-1:0]      p_row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  acc_sum;
    logic                     f_vld_reg;
    logic [CH_IDX_W-1:0]      f_row_reg;
    logic signed [ACC_W-1:0]  fin_reg;
    logic [ACC_W-1:0]         rnd;
    logic [SHF_W-1:0]         shf;
    logic                     fits;
    logic [OUT_W-1:0]         sat;
    logic                     res_vld_reg;
    logic [CH_IDX_W-1:0]      res_row_reg;
    logic [OUT_W-1:0]         res_val_reg;

    always_comb
    begin
        run_next = run_reg;
        k_next   = k_reg;
        i_next   = i_reg;
        r_next   = r_reg;
        if (start)
        begin
            run_next = 1'b1;
            k_next   = '0;
            i_next   = '0;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            k_next = k_reg + 1'b1;
            if (i_reg == CH_IDX_W'(N_CH - 1))
            begin
                i_next = '0;
                r_next = r_reg + 1'b1;
            end
            else
            begin
                i_next = i_reg + 1'b1;
            end
            if (k_reg == COEF_IDX_W'(N_COEF - 1))
            begin
                run_next = 1'b0;
            end
        end
    end

    assign prod_next = PROD_W'(coef_rom(k_reg)) * PROD_W'(d_reg[i_reg]);
    assign acc_base  = p_first_reg ? '0 : acc_reg;
    assign acc_sum   = acc_base + ACC_W'(prod_reg);

    // Round half up to Q.16, then clamp to the 32-bit range
    always_comb
    begin
        rnd  = fin_reg + ACC_W'(RND_HALF);
        shf  = rnd[ACC_W-1:RND_SH];
        fits = (shf[SHF_W-1:OUT_W-1] == {TOP_W{1'b0}})
            || (shf[SHF_W-1:OUT_W-1] == {TOP_W{1'b1}});
        if (fits)
        begin
            sat = shf[OUT_W-1:0];
        end
        else if (shf[SHF_W-1])
        begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            r_reg       <= '0;
            p_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            r_reg       <= r_next;
            p_vld_reg   <= run_reg;
            f_vld_reg   <= p_vld_reg && p_last_reg;
            res_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            d_reg[load.idx] <= signed'(load.value);
        end
        if (run_reg)
        begin
            prod_reg    <= prod_next;
            p_first_reg <= (i_reg == '0);
            p_last_reg  <= (i_reg == CH_IDX_W'(N_CH - 1));
            p_row_reg   <= r_reg;
        end
        if (p_vld_reg)
        begin
            acc_reg <= acc_sum;
            if (p_last_reg)
            begin
                fin_reg   <= acc_sum;
                f_row_reg <= p_row_reg;
            end
        end
        if (f_vld_reg)
        begin
            res_row_reg <= f_row_reg;
            res_val_reg <= sat;
        end
    end

    assign res = {res_vld_reg, res_row_reg, res_val_reg};

endmodule

// File: sim/tb_six_axis_force_torque_conversion.sv
// Self-checking testbench for the six-axis force/torque conversion block
`timescale 1ns / 100ps

module tb_six_axis_force_torque_conversion;
    import sftc_pkg::*;

    localparam int MAX_SAMPLES = 1024;
    localparam int HOLD_CYC    = 400;
    localparam logic [APB_AW-1:0] REG_SPA = 3'd0;

    typedef struct packed
    {
        logic                  is_cfg;
        logic [SPA_W-1:0]      spa;
        opcode_t               op;
        logic [IN_DATA_W-1:0]  volts;
        logic                  typed;
        logic [OUT_DATA_W-1:0] want;
    } script_row_t;

    typedef struct packed
    {
        logic                  typed;
        logic [OUT_DATA_W-1:0] want;
    } ft_note_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // volt_ch0 [15:0], volt_ch1, volt_ch2, volt_ch3, volt_ch4, volt_ch5 [95:80]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // opcode [0]
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // force_x [31:0], force_y, force_z, torque_x, torque_y, torque_z [191:160]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    six_axis_force_torque_conversion u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Calibration matrix, row-major, Q15.16
    int cal_q16 [N_COEF] = '{
            143,     509,   -5067,  -217024,     1482,   215589,
          -1740,  265964,   -4017,  -123758,     -489,  -125769,
         248437,     131,  249991,    -4060,   250041,    -4861,
         -50630, 1601312, 1369506,  -766155, -1424086,  -733852,
       -1545934,   -5793,  837068,  1299424,   851258, -1317759,
            912,  942802,   24145,   916621,    16861,   953783
    };

    string axis_name [N_CH] = '{"force_x", "force_y", "force_z",
                                "torque_x", "torque_y", "torque_z"};

    // Predictor state
    logic [SPA_W-1:0]      spa_cfg = 11'd1;
    longint                gauge_sum [N_CH];
    longint                zero_off [N_CH];
    int unsigned           run_count = 0;
    opcode_t               run_op = OP_MEASURE;

    logic [OUT_DATA_W-1:0] wrench_q [$];
    ft_note_t              note_q [$];
    int                    mismatch_cnt = 0;
    bit                    calm = 1'b0;
    bit                    jitter = 1'b1;
    int                    stall_left = 0;

    initial
    begin
        foreach (gauge_sum[i])
        begin
            gauge_sum[i] = 0;
            zero_off[i]  = 0;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_volts(input int a, b, c, d, e, f);
        return {f[15:0], e[15:0], d[15:0], c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic logic [OUT_DATA_W-1:0] pack_wrench(input int a, b, c, d, e, f);
        return {f, e, d, c, b, a};
    endfunction

    function automatic logic [VOLT_W-1:0] rand_volt();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4:
            begin
                k = $urandom_range(0, 600);
                return 16'(k - 300);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_volts();
        return {rand_volt(), rand_volt(), rand_volt(), rand_volt(), rand_volt(), rand_volt()};
    endfunction

    function automatic script_row_t cfg_row(input int spa);
        return '{1'b1, spa[SPA_W-1:0], OP_MEASURE, '0, 1'b0, '0};
    endfunction

    function automatic script_row_t smp_row(input opcode_t op, input logic [IN_DATA_W-1:0] v);
        return '{1'b0, '0, op, v, 1'b0, '0};
    endfunction

    function automatic script_row_t chk_row(input logic [IN_DATA_W-1:0] v,
                                            input logic [OUT_DATA_W-1:0] w);
        return '{1'b0, '0, OP_MEASURE, v, 1'b1, w};
    endfunction

    // Average, remove offset, apply calibration matrix
    task automatic accumulate_sample(input opcode_t op, input logic [IN_DATA_W-1:0] v);
        int unsigned           len;
        logic signed [VOLT_W-1:0] s;
        longint                avg [N_CH];
        longint                d;
        longint                acc;
        longint                y;
        logic [OUT_DATA_W-1:0] ft;
        ft_note_t              note;
        note = note_q.pop_front();
        len = (spa_cfg == 0) ? 1 : ((spa_cfg > MAX_SAMPLES) ? MAX_SAMPLES : spa_cfg);
        // drop the partial run on a change of opcode
        if (run_count != 0 && op != run_op)
        begin
            foreach (gauge_sum[i])
                gauge_sum[i] = 0;
            run_count = 0;
        end
        run_op = op;
        for (int i = 0; i < N_CH; i++)
        begin
            s = v[i*VOLT_W +: VOLT_W];
            gauge_sum[i] += s;
        end
        run_count++;
        if (run_count >= len)
        begin
            for (int i = 0; i < N_CH; i++)
                avg[i] = gauge_sum[i] / longint'(run_count);
            foreach (gauge_sum[i])
                gauge_sum[i] = 0;
            run_count = 0;
            if (op == OP_OFFSET)
            begin
                for (int i = 0; i < N_CH; i++)
                    zero_off[i] = avg[i];
            end
            else
            begin
                for (int r = 0; r < N_CH; r++)
                begin
                    acc = 0;
                    for (int i = 0; i < N_CH; i++)
                    begin
                        d = avg[i] - zero_off[i];
                        if (d > 65535)
                            d = 65535;
                        if (d < -65536)
                            d = -65536;
                        acc += longint'(cal_q16[r*N_CH + i]) * d;
                    end
                    y = (acc + RND_HALF) >>> RND_SH;
                    if (y > 64'sd2147483647)
                        y = 64'sd2147483647;
                    if (y < -64'sd2147483648)
                        y = -64'sd2147483648;
                    ft[r*OUT_W +: OUT_W] = y[31:0];
                end
                wrench_q.push_back(note.typed ? note.want : ft);
            end
        end
    endtask

    // Track register writes and accepted requests
    always @(posedge clk)
    begin : follow_block
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == REG_SPA)
                spa_cfg = pwdata[SPA_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                accumulate_sample(opcode_t'(s_axis_tuser), s_axis_tdata);
        end
    end

    always @(posedge clk)
    begin : check_block
        logic [OUT_DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (wrench_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = wrench_q.pop_front();
                for (int f = 0; f < N_CH; f++)
                begin
                    if (m_axis_tdata[f*OUT_W +: OUT_W] !== want[f*OUT_W +: OUT_W])
                    begin
                        $display("%0t: %s expected %0d actual %0d", $time, axis_name[f],
                                 $signed(want[f*OUT_W +: OUT_W]),
                                 $signed(m_axis_tdata[f*OUT_W +: OUT_W]));
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Output back-pressure in bursts of random length
    always @(posedge clk)
    begin : sink_pace
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (calm || !jitter)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input opcode_t op, input logic [IN_DATA_W-1:0] v,
                               input logic typed, input logic [OUT_DATA_W-1:0] want);
        int gap;
        if (jitter && !calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_q.push_back(ft_note_t'{typed, want});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (wrench_q.size() != 0);
    endtask

    // Drain, then let the last run-ending request finish inside the block
    task automatic settle();
        drain_results();
        repeat (HOLD_CYC) @(posedge clk);
    endtask

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stim
        script_row_t script [$];
        int          pick;
        int          spa;
        int          sent;
        int          run;
        bit          first;
        opcode_t     op;

        // run length 1 after reset, zero offsets
        script.push_back(chk_row(pack_volts(0, 0, 0, 0, 0, 0), '0));
        script.push_back(chk_row(pack_volts(2048, 0, 0, 0, 0, 0),
                                 pack_wrench(143, -1740, 248437, -50630, -1545934, 912)));
        script.push_back(chk_row(pack_volts(0, 0, 0, 2048, 0, 0),
                                 pack_wrench(-217024, -123758, -4060, -766155, 1299424, 916621)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(32767, 32767, 32767, 32767, 32767, 32767)));
        script.push_back(smp_row(OP_MEASURE,
                                 pack_volts(-32768, -32768, -32768, -32768, -32768, -32768)));
        script.push_back(smp_row(OP_MEASURE,
                                 pack_volts(32767, -32768, 32767, -32768, 32767, -32768)));
        // widest differences in both directions
        script.push_back(smp_row(OP_OFFSET,
                                 pack_volts(-32768, -32768, -32768, -32768, -32768, -32768)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(32767, 32767, 32767, 32767, 32767, 32767)));
        script.push_back(smp_row(OP_OFFSET, pack_volts(32767, 32767, 32767, 32767, 32767, 32767)));
        script.push_back(smp_row(OP_MEASURE,
                                 pack_volts(-32768, -32768, -32768, -32768, -32768, -32768)));
        // zero length acts as one
        script.push_back(cfg_row(0));
        script.push_back(smp_row(OP_OFFSET, pack_volts(0, 0, 0, 0, 0, 0)));
        script.push_back(chk_row(pack_volts(2048, 0, 0, 0, 0, 0),
                                 pack_wrench(143, -1740, 248437, -50630, -1545934, 912)));
        // opcode change mid-run restarts the sums
        script.push_back(cfg_row(3));
        script.push_back(smp_row(OP_MEASURE, pack_volts(100, -200, 300, -400, 500, -600)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(7, 7, 7, 7, 7, 7)));
        script.push_back(smp_row(OP_OFFSET, pack_volts(-1, 1, -5, 5, -2, 2)));
        script.push_back(smp_row(OP_OFFSET, pack_volts(-1, 1, -3, 4, -2, 3)));
        script.push_back(smp_row(OP_OFFSET, pack_volts(-3, 0, -2, 4, -1, 3)));
        // shorter length written while a run is open; negative sums truncate toward zero
        script.push_back(smp_row(OP_MEASURE, pack_volts(-1, -700, 1000, -2, 3, -9)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(-1, 250, 999, -2, 4, -9)));
        script.push_back(cfg_row(2));
        script.push_back(smp_row(OP_MEASURE, pack_volts(-2, 33, 1000, -3, 4, -10)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(-5, -1, 2, 3, -4, 5)));
        script.push_back(smp_row(OP_MEASURE, pack_volts(-6, -2, 1, 4, -3, 6)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                settle();
                reg_write(REG_SPA, APB_DW'(script[k].spa));
            end
            else
                send_sample(script[k].op, script[k].volts, script[k].typed, script[k].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            settle();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                spa = 0;
            else if (pick == 1)
                spa = $urandom_range(5, 9);
            else
                spa = $urandom_range(1, 4);
            reg_write(REG_SPA, APB_DW'(spa));
            jitter = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
            begin
                // mostly complete runs, sometimes an offset capture, now and then cut short
                sent  = 0;
                first = 1'b1;
                while (sent < 36)
                begin
                    run = (spa == 0) ? 1 : spa;
                    if ((first && $urandom_range(0, 1) == 1) || $urandom_range(0, 5) == 0)
                        op = OP_OFFSET;
                    else
                        op = OP_MEASURE;
                    if ($urandom_range(0, 7) == 0)
                        run = $urandom_range(1, run);
                    for (int j = 0; j < run; j++)
                    begin
                        if (jitter && $urandom_range(0, 39) == 0)
                            drain_results();
                        send_sample(op, rand_volts(), 1'b0, '0);
                    end
                    sent += run;
                    first = 1'b0;
                end
            end
            else
            begin
                for (int j = 0; j < 36; j++)
                begin
                    op = ($urandom_range(0, 1) == 1) ? OP_OFFSET : OP_MEASURE;
                    send_sample(op, rand_volts(), 1'b0, '0);
                end
            end
        end

        // length above the maximum, then full-scale runs, no random gaps or stalls from here on
        settle();
        calm = 1'b1;
        reg_write(REG_SPA, APB_DW'(11'h7FF));
        repeat (3)
            send_sample(OP_MEASURE, rand_volts(), 1'b0, '0);
        settle();
        reg_write(REG_SPA, APB_DW'(32));
        repeat (32)
            send_sample(OP_OFFSET, pack_volts(-32768, -32768, -32768, -32768, -32768, -32768),
                        1'b0, '0);
        repeat (32)
            send_sample(OP_MEASURE, pack_volts(32767, 32767, 32767, 32767, 32767, 32767),
                        1'b0, '0);
        repeat (3)
            send_sample(OP_MEASURE, rand_volts(), 1'b0, '0);

        settle();
        if (mismatch_cnt == 0 && wrench_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
